FILE: design/ils_pkg.sv
// Shared types and codes for the indexed list store.
package ils_pkg;

    localparam int OP_W   = 3;
    localparam int POS_W  = 5;
    localparam int DATA_W = 16;
    localparam int STAT_W = 2;
    localparam int FIDX_W = 4;
    localparam int ECNT_W = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD_END   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_START = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT_AT = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_END   = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_START = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;
    localparam logic [OP_W-1:0] OP_READ_AT   = 3'd6;
    localparam logic [OP_W-1:0] OP_FIND      = 3'd7;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] weight;
        logic        [DATA_W-1:0] payload;
    } entry_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic                     ins_en;    // shift up, write new entry at target
        logic                     del_en;    // shift down from target
        logic                     by_weight; // search by key instead of index
        logic signed [DATA_W-1:0] key;
        entry_t                   new_entry;
    } cell_ctrl_t;

endpackage

FILE: design/ils_cell.sv
// One list slot: stored entry, shift muxing and a stage of the search carry.
module ils_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4,
    parameter int CW  = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ils_pkg::cell_ctrl_t ctrl,
    input  logic [IW-1:0]       tgt,
    input  logic [CW-1:0]       cnt,
    input  ils_pkg::entry_t     left_entry,
    input  ils_pkg::entry_t     right_entry,
    output ils_pkg::entry_t     entry,
    input  logic                carry_in_hit,
    input  logic [IW-1:0]       carry_in_idx,
    input  ils_pkg::entry_t     carry_in_entry,
    output logic                carry_hit,
    output logic [IW-1:0]       carry_idx,
    output ils_pkg::entry_t     carry_entry
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);
    localparam logic [CW-1:0] MY_POS = CW'(IDX);

    ils_pkg::entry_t entry_reg;
    ils_pkg::entry_t entry_next;
    logic            hit_reg;
    logic            hit_next;
    logic [IW-1:0]   idx_reg;
    logic [IW-1:0]   idx_next;
    ils_pkg::entry_t cent_reg;
    ils_pkg::entry_t cent_next;
    logic            match;

    assign match = ctrl.by_weight ? ((entry_reg.weight == ctrl.key) && (MY_POS < cnt))
                                  : (MY_IDX == tgt);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins_en)
        begin
            if (MY_IDX > tgt)
                entry_next = left_entry;
            else if (MY_IDX == tgt)
                entry_next = ctrl.new_entry;
        end
        else if (ctrl.del_en)
        begin
            if (MY_IDX >= tgt)
                entry_next = right_entry;
        end
    end

    // First match wins; later cells pass the carry on unchanged
    always_comb
    begin
        hit_next  = carry_in_hit;
        idx_next  = carry_in_idx;
        cent_next = carry_in_entry;
        if (match && !carry_in_hit)
        begin
            hit_next  = 1'b1;
            idx_next  = MY_IDX;
            cent_next = entry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        idx_reg   <= idx_next;
        cent_reg  <= cent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else
            hit_reg <= hit_next;
    end

    assign entry       = entry_reg;
    assign carry_hit   = hit_reg;
    assign carry_idx   = idx_reg;
    assign carry_entry = cent_reg;

endmodule

FILE: design/indexed_list_store.sv
// Top level of the indexed list store: request sequencer and cell chain.
//
// Ordered list of up to CAPACITY entries (signed 16-bit weight plus 16-bit
// payload), one cell per slot. Requests arrive on the in_valid/in_ready
// channel (operation, position, entry_weight, entry_payload); each request
// yields exactly one result on the out_valid/out_ready channel (status,
// found_index, out_weight, out_payload, entry_count).
// A request is checked against the current count when it is taken. A search
// carry then walks the cell chain, one cell per cycle, picking up the entry
// at the target index or the first entry whose weight matches. When the
// carry leaves the last cell the whole list is shifted at once (inserts move
// later cells up, removals move them down) and the result is registered.
// One request is in flight at a time; in_ready rises together with out_valid,
// so a new request may enter while the previous result still waits for
// out_ready. If that result is still waiting when the walk ends, the
// sequencer holds (list not yet updated) until the output register is free.
// Reset clears the count and the handshake state; cell contents are left
// as they are and are never read before being written.
module indexed_list_store #(
    parameter int CAPACITY = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ils_pkg::OP_W-1:0]            operation,
    input  logic [ils_pkg::POS_W-1:0]           position,
    input  logic signed [ils_pkg::DATA_W-1:0]   entry_weight,
    input  logic [ils_pkg::DATA_W-1:0]          entry_payload,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ils_pkg::STAT_W-1:0]          status,
    output logic [ils_pkg::FIDX_W-1:0]          found_index,
    output logic signed [ils_pkg::DATA_W-1:0]   out_weight,
    output logic [ils_pkg::DATA_W-1:0]          out_payload,
    output logic [ils_pkg::ECNT_W-1:0]          entry_count
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    // Sequencer state
    logic [1:0]                    state_reg, state_next;
    logic [IW-1:0]                 step_reg, step_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [ils_pkg::OP_W-1:0]      op_reg;
    logic [IW-1:0]                 tgt_reg;
    logic                          rej_reg;
    ils_pkg::entry_t               new_reg;

    // Output register
    logic                          out_valid_reg, out_valid_next;
    logic [ils_pkg::STAT_W-1:0]    status_reg, status_next;
    logic [ils_pkg::FIDX_W-1:0]    fidx_reg, fidx_next;
    ils_pkg::entry_t               oent_reg, oent_next;
    logic [ils_pkg::ECNT_W-1:0]    ecnt_reg, ecnt_next;

    // Request decode
    logic                          accept;
    logic                          commit;
    logic                          full;
    logic                          empty;
    logic [CMPW-1:0]               pos_ext;
    logic [CMPW-1:0]               cnt_ext;
    logic [IW-1:0]                 tgt_dec;
    logic                          rej_dec;
    logic                          is_ins;
    logic                          is_del;

    // Chain wiring
    ils_pkg::cell_ctrl_t           ctrl;
    ils_pkg::entry_t               ent   [CAPACITY];
    logic                          c_hit [CAPACITY];
    logic [IW-1:0]                 c_idx [CAPACITY];
    ils_pkg::entry_t               c_ent [CAPACITY];

    assign accept  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign commit  = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign pos_ext = CMPW'(position);
    assign cnt_ext = CMPW'(count_reg);

    always_comb
    begin
        tgt_dec = '0;
        rej_dec = 1'b0;
        unique case (operation) inside
            ils_pkg::OP_ADD_END:
            begin
                tgt_dec = IW'(count_reg);
                rej_dec = full;
            end
            ils_pkg::OP_ADD_START:
            begin
                rej_dec = full;
            end
            ils_pkg::OP_INSERT_AT:
            begin
                tgt_dec = IW'(position);
                rej_dec = full || (pos_ext > cnt_ext);
            end
            ils_pkg::OP_DEL_END:
            begin
                tgt_dec = IW'(count_reg - CW'(1));
                rej_dec = empty;
            end
            ils_pkg::OP_DEL_START:
            begin
                rej_dec = empty;
            end
            ils_pkg::OP_DEL_AT, ils_pkg::OP_READ_AT:
            begin
                tgt_dec = IW'(position);
                rej_dec = (pos_ext >= cnt_ext);
            end
            default:
            begin
                // find never rejects
                rej_dec = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        is_ins = 1'b0;
        is_del = 1'b0;
        unique case (op_reg) inside
            ils_pkg::OP_ADD_END, ils_pkg::OP_ADD_START, ils_pkg::OP_INSERT_AT:
                is_ins = 1'b1;
            ils_pkg::OP_DEL_END, ils_pkg::OP_DEL_START, ils_pkg::OP_DEL_AT:
                is_del = 1'b1;
            default:
                is_ins = 1'b0;
        endcase
    end

    // Shifts are applied only on the commit cycle
    always_comb
    begin
        ctrl.ins_en    = commit && !rej_reg && is_ins;
        ctrl.del_en    = commit && !rej_reg && is_del;
        ctrl.by_weight = (op_reg == ils_pkg::OP_FIND);
        ctrl.key       = new_reg.weight;
        ctrl.new_entry = new_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (accept)
                    state_next = S_WALK;
            end
            S_WALK:
            begin
                if (step_reg == IW'(CAPACITY - 1))
                    state_next = S_FINISH;
                else
                    step_next = step_reg + IW'(1);
            end
            S_FINISH:
            begin
                if (commit)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Result formation from the tail of the chain
    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        fidx_next   = fidx_reg;
        oent_next   = oent_reg;
        ecnt_next   = ecnt_reg;
        if (commit)
        begin
            if (!rej_reg && is_ins)
                count_next = count_reg + CW'(1);
            else if (!rej_reg && is_del)
                count_next = count_reg - CW'(1);
            ecnt_next = ils_pkg::ECNT_W'(count_next);
            if (rej_reg)
            begin
                status_next = ils_pkg::ST_REJECT;
                fidx_next   = '0;
                oent_next   = '0;
            end
            else if (is_ins)
            begin
                status_next = ils_pkg::ST_DONE;
                fidx_next   = ils_pkg::FIDX_W'(tgt_reg);
                oent_next   = new_reg;
            end
            else if (op_reg == ils_pkg::OP_FIND)
            begin
                if (c_hit[CAPACITY-1])
                begin
                    status_next = ils_pkg::ST_DONE;
                    fidx_next   = ils_pkg::FIDX_W'(c_idx[CAPACITY-1]);
                    oent_next   = c_ent[CAPACITY-1];
                end
                else
                begin
                    status_next = ils_pkg::ST_NOTFOUND;
                    fidx_next   = '0;
                    oent_next   = '0;
                end
            end
            else
            begin
                status_next = ils_pkg::ST_DONE;
                fidx_next   = ils_pkg::FIDX_W'(tgt_reg);
                oent_next   = c_ent[CAPACITY-1];
            end
        end
    end

    assign out_valid_next = commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg          <= operation;
            tgt_reg         <= tgt_dec;
            rej_reg         <= rej_dec;
            new_reg.weight  <= entry_weight;
            new_reg.payload <= entry_payload;
        end
        status_reg <= status_next;
        fidx_reg   <= fidx_next;
        oent_reg   <= oent_next;
        ecnt_reg   <= ecnt_next;
    end

    // Cell chain
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        ils_pkg::entry_t left_w;
        ils_pkg::entry_t right_w;
        logic            cin_hit;
        logic [IW-1:0]   cin_idx;
        ils_pkg::entry_t cin_ent;

        if (g == 0)
        begin : g_head
            assign left_w  = new_reg;
            assign cin_hit = 1'b0;
            assign cin_idx = '0;
            assign cin_ent = '0;
        end
        else
        begin : g_body
            assign left_w  = ent[g-1];
            assign cin_hit = c_hit[g-1];
            assign cin_idx = c_idx[g-1];
            assign cin_ent = c_ent[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_w = ent[g];
        end
        else
        begin : g_mid
            assign right_w = ent[g+1];
        end

        ils_cell #(
            .IDX (g),
            .IW  (IW),
            .CW  (CW)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctrl           (ctrl),
            .tgt            (tgt_reg),
            .cnt            (count_reg),
            .left_entry     (left_w),
            .right_entry    (right_w),
            .entry          (ent[g]),
            .carry_in_hit   (cin_hit),
            .carry_in_idx   (cin_idx),
            .carry_in_entry (cin_ent),
            .carry_hit      (c_hit[g]),
            .carry_idx      (c_idx[g]),
            .carry_entry    (c_ent[g])
        );
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_index = fidx_reg;
    assign out_weight  = oent_reg.weight;
    assign out_payload = oent_reg.payload;
    assign entry_count = ecnt_reg;

endmodule

FILE: design/ils_checker.sv
// Port-level checks for the indexed list store, bound to the top level.
module ils_checker #(
    parameter int CAPACITY = 16
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic [ils_pkg::OP_W-1:0]            operation,
    input logic [ils_pkg::POS_W-1:0]           position,
    input logic signed [ils_pkg::DATA_W-1:0]   entry_weight,
    input logic [ils_pkg::DATA_W-1:0]          entry_payload,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [ils_pkg::STAT_W-1:0]          status,
    input logic [ils_pkg::FIDX_W-1:0]          found_index,
    input logic signed [ils_pkg::DATA_W-1:0]   out_weight,
    input logic [ils_pkg::DATA_W-1:0]          out_payload,
    input logic [ils_pkg::ECNT_W-1:0]          entry_count
);

    localparam logic [31:0] CAP_U = 32'(CAPACITY);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found_index)
            && $stable(out_weight) && $stable(out_payload) && $stable(entry_count))
        else $error("result changed while stalled");

    // a waiting request holds its fields
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(operation) && $stable(position)
            && $stable(entry_weight) && $stable(entry_payload))
        else $error("request changed while waiting");

    // one request in flight: ready drops after a request is taken
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second request taken while one is in flight");

    // rejected and not-found results carry no entry
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ils_pkg::ST_REJECT || status == ils_pkg::ST_NOTFOUND)
            |-> found_index == '0 && out_weight == '0 && out_payload == '0)
        else $error("rejected or not-found result carries data");

    // reported count never exceeds the capacity
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (CAP_U > 32'd31) || (32'(entry_count) <= CAP_U))
        else $error("entry count above capacity");

endmodule

bind indexed_list_store ils_checker #(.CAPACITY(CAPACITY)) u_ils_checker (.*);

FILE: sim/indexed_list_store_tb.sv
// Testbench for indexed_list_store: directed and random list requests checked against a local list model.
module indexed_list_store_tb;

    import ils_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 600000;
    localparam int IDLE_PCT    = 32;

    // One result as the block reports it
    typedef struct {
        logic [STAT_W-1:0]        status;
        logic [FIDX_W-1:0]        index;
        logic signed [DATA_W-1:0] weight;
        logic [DATA_W-1:0]        payload;
        logic [ECNT_W-1:0]        count;
    } list_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [OP_W-1:0]            operation;
    logic [POS_W-1:0]           position;
    logic signed [DATA_W-1:0]   entry_weight;
    logic [DATA_W-1:0]          entry_payload;
    logic                       out_valid;
    logic                       out_ready;
    logic [STAT_W-1:0]          status;
    logic [FIDX_W-1:0]          found_index;
    logic signed [DATA_W-1:0]   out_weight;
    logic [DATA_W-1:0]          out_payload;
    logic [ECNT_W-1:0]          entry_count;

    // Local copy of the list, updated as each request is accepted
    logic signed [DATA_W-1:0]   list_weights [CAPACITY];
    logic [DATA_W-1:0]          list_payloads [CAPACITY];
    int                         list_len;

    list_result_t               pending_results [$];

    bit                         no_idle;
    int                         error_count;
    int                         cycle_count;
    int                         requests_sent;
    int                         results_checked;
    int                         reject_total;
    int                         notfound_total;
    int                         full_rejects;

    indexed_list_store #(
        .CAPACITY (CAPACITY)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .position      (position),
        .entry_weight  (entry_weight),
        .entry_payload (entry_payload),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .found_index   (found_index),
        .out_weight    (out_weight),
        .out_payload   (out_payload),
        .entry_count   (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out the result of one accepted request and updates the local list.
    task automatic predict_list_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                   input logic signed [DATA_W-1:0] w,
                                   input logic [DATA_W-1:0] p);
        list_result_t r;
        int           target;
        int           k;
        bit           hit;
        r.status  = ST_REJECT;
        r.index   = '0;
        r.weight  = '0;
        r.payload = '0;
        target    = int'(pos);
        hit       = 1'b0;
        case (op)
            OP_ADD_END, OP_ADD_START, OP_INSERT_AT:
            begin
                if (op == OP_ADD_END)
                    target = list_len;
                else if (op == OP_ADD_START)
                    target = 0;
                if (list_len >= CAPACITY)
                    full_rejects++;
                if (list_len < CAPACITY && target <= list_len)
                begin
                    for (k = list_len; k > target; k--)
                    begin
                        list_weights[k]  = list_weights[k-1];
                        list_payloads[k] = list_payloads[k-1];
                    end
                    list_weights[target]  = w;
                    list_payloads[target] = p;
                    list_len++;
                    r.status  = ST_DONE;
                    r.index   = target[FIDX_W-1:0];
                    r.weight  = w;
                    r.payload = p;
                end
            end
            OP_DEL_END, OP_DEL_START, OP_DEL_AT:
            begin
                if (op == OP_DEL_END)
                    target = (list_len == 0) ? 0 : list_len - 1;
                else if (op == OP_DEL_START)
                    target = 0;
                if (list_len > 0 && target < list_len)
                begin
                    r.status  = ST_DONE;
                    r.index   = target[FIDX_W-1:0];
                    r.weight  = list_weights[target];
                    r.payload = list_payloads[target];
                    for (k = target; k + 1 < list_len; k++)
                    begin
                        list_weights[k]  = list_weights[k+1];
                        list_payloads[k] = list_payloads[k+1];
                    end
                    list_len--;
                end
            end
            OP_READ_AT:
            begin
                if (target < list_len)
                begin
                    r.status  = ST_DONE;
                    r.index   = target[FIDX_W-1:0];
                    r.weight  = list_weights[target];
                    r.payload = list_payloads[target];
                end
            end
            default:
            begin
                // first match wins
                r.status = ST_NOTFOUND;
                for (k = 0; k < list_len; k++)
                begin
                    if (!hit && list_weights[k] == w)
                    begin
                        hit       = 1'b1;
                        r.status  = ST_DONE;
                        r.index   = k[FIDX_W-1:0];
                        r.weight  = list_weights[k];
                        r.payload = list_payloads[k];
                    end
                end
            end
        endcase
        if (r.status == ST_REJECT)
            reject_total++;
        if (r.status == ST_NOTFOUND)
            notfound_total++;
        r.count = list_len[ECNT_W-1:0];
        pending_results.push_back(r);
    endtask

    // Drives one request: random gaps first, then holds it until accepted.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic signed [DATA_W-1:0] w,
                                input logic [DATA_W-1:0] p);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        operation     <= op;
        position      <= pos;
        entry_weight  <= w;
        entry_payload <= p;
        do
            @(posedge clk);
        while (!in_ready);
        requests_sent++;
        predict_list_op(op, pos, w, p);
    endtask

    // Random requests; add_pct and del_pct steer the list length up or down.
    task automatic random_requests(input int n, input int add_pct, input int del_pct);
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] w;
        int                       roll;
        int                       i;
        for (i = 0; i < n; i++)
        begin
            roll = $urandom_range(99);
            if (roll < add_pct)
            begin
                case ($urandom_range(2))
                    0:       op = OP_ADD_END;
                    1:       op = OP_ADD_START;
                    default: op = OP_INSERT_AT;
                endcase
            end
            else if (roll < add_pct + del_pct)
            begin
                case ($urandom_range(2))
                    0:       op = OP_DEL_END;
                    1:       op = OP_DEL_START;
                    default: op = OP_DEL_AT;
                endcase
            end
            else
                op = $urandom_range(1) ? OP_READ_AT : OP_FIND;

            // mostly in range, some anywhere in 0..16
            if ($urandom_range(99) < 80)
                pos = POS_W'($urandom_range(list_len));
            else
                pos = POS_W'($urandom_range(16));

            // reuse stored weights so finds hit, plus the extremes and noise
            roll = $urandom_range(99);
            if (roll < 40 && list_len > 0)
                w = list_weights[$urandom_range(list_len - 1)];
            else if (roll < 65)
            begin
                case ($urandom_range(3))
                    0:       w = 16'sh8000;
                    1:       w = 16'sh7fff;
                    2:       w = 16'sh0000;
                    default: w = -16'sd1;
                endcase
            end
            else
                w = DATA_W'($urandom);
            send_request(op, pos, w, DATA_W'($urandom));
        end
    endtask

    task automatic test_empty_list;
        send_request(OP_READ_AT,   5'd0,  16'sd0, 16'h0000);
        send_request(OP_DEL_END,   5'd0,  16'sd0, 16'h0000);
        send_request(OP_DEL_START, 5'd0,  16'sd0, 16'h0000);
        send_request(OP_DEL_AT,    5'd0,  16'sd0, 16'h0000);
        send_request(OP_FIND,      5'd0,  16'sd0, 16'h0000);
        send_request(OP_INSERT_AT, 5'd1,  16'sd7, 16'h0007);
    endtask

    task automatic test_insert_and_read;
        send_request(OP_ADD_END,   5'd0,  16'sh7fff, 16'hffff);
        send_request(OP_ADD_START, 5'd0,  16'sh8000, 16'h0000);
        send_request(OP_INSERT_AT, 5'd2,  16'sh0000, 16'h1234);  // at count: acts as add end
        send_request(OP_INSERT_AT, 5'd1,  -16'sd1,   16'h8000);
        send_request(OP_READ_AT,   5'd3,  16'sd0,    16'h0000);
        send_request(OP_READ_AT,   5'd4,  16'sd0,    16'h0000);  // one past the end
        send_request(OP_FIND,      5'd0,  -16'sd1,   16'h0000);
        send_request(OP_FIND,      5'd0,  16'sd5,    16'h0000);
    endtask

    task automatic test_remove_ops;
        send_request(OP_DEL_AT,    5'd1,  16'sd0, 16'h0000);
        send_request(OP_DEL_START, 5'd0,  16'sd0, 16'h0000);
        send_request(OP_DEL_END,   5'd0,  16'sd0, 16'h0000);
        send_request(OP_DEL_AT,    5'd5,  16'sd0, 16'h0000);
        send_request(OP_INSERT_AT, 5'd16, 16'sd0, 16'h0000);
    endtask

    task automatic test_full_list;
        while (list_len < CAPACITY)
            send_request(OP_ADD_END, 5'd0, DATA_W'($urandom), DATA_W'($urandom));
        send_request(OP_ADD_END,   5'd0,  16'sd1, 16'h0001);
        send_request(OP_ADD_START, 5'd0,  16'sd1, 16'h0001);
        send_request(OP_INSERT_AT, 5'd8,  16'sd1, 16'h0001);
        send_request(OP_READ_AT,   5'd15, 16'sd0, 16'h0000);
        send_request(OP_READ_AT,   5'd16, 16'sd0, 16'h0000);
        send_request(OP_DEL_AT,    5'd15, 16'sd0, 16'h0000);
    endtask

    // Long stretch with both sides always ready
    task automatic test_back_to_back;
        no_idle = 1'b1;
        random_requests(300, 35, 35);
        no_idle = 1'b0;
    endtask

    task automatic test_random_growth;
        random_requests(400, 60, 20);
    endtask

    task automatic test_random_shrink;
        random_requests(400, 20, 60);
    endtask

    task automatic test_random_mix;
        random_requests(850, 35, 35);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual status %0d index %0d",
                         $realtime, status, found_index);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                compare_field("status",      int'(want.status),  int'(status));
                compare_field("found_index", int'(want.index),   int'(found_index));
                compare_field("out_weight",  int'(want.weight),  int'(out_weight));
                compare_field("out_payload", int'(want.payload), int'(out_payload));
                compare_field("entry_count", int'(want.count),   int'(entry_count));
            end
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
        out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_ready     = 1'b0;
        operation     = OP_ADD_END;
        position      = '0;
        entry_weight  = '0;
        entry_payload = '0;
        no_idle       = 1'b0;
        list_len      = 0;
        error_count   = 0;
        cycle_count   = 0;
        requests_sent   = 0;
        results_checked = 0;
        reject_total    = 0;
        notfound_total  = 0;
        full_rejects    = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_insert_and_read();
        test_remove_ops();
        test_full_list();
        test_back_to_back();
        test_random_growth();
        test_random_shrink();
        test_random_mix();

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (CAPACITY + 4) @(posedge clk);

        $display("Ran %0d list requests over all eight operations, %0d results checked.",
                 requests_sent, results_checked);
        $display("Rejected %0d (%0d on a full list), %0d searches found nothing.",
                 reject_total, full_rejects, notfound_total);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: indexed_list_store.f
design/ils_pkg.sv
design/ils_cell.sv
design/indexed_list_store.sv
design/ils_checker.sv
sim/indexed_list_store_tb.sv
